@@ hw/rtl/aie_pkg.sv @@
// shared types and codes for the accumulator instruction execute block
package aie_pkg;

	localparam logic [3:0] OP_SET   = 4'd0;
	localparam logic [3:0] OP_LOAD  = 4'd1;
	localparam logic [3:0] OP_ADD   = 4'd2;
	localparam logic [3:0] OP_SUB   = 4'd3;
	localparam logic [3:0] OP_INC   = 4'd4;
	localparam logic [3:0] OP_DEC   = 4'd5;
	localparam logic [3:0] OP_STR   = 4'd6;
	localparam logic [3:0] OP_SHW   = 4'd7;
	localparam logic [3:0] OP_PAUSE = 4'd8;
	localparam logic [3:0] OP_END   = 4'd9;

	localparam logic [1:0] BK_NULL = 2'd0;
	localparam logic [1:0] BK_ADDR = 2'd1;
	localparam logic [1:0] BK_NUM  = 2'd2;

	localparam logic [1:0] CK_NULL = 2'd0;
	localparam logic [1:0] CK_ADDR = 2'd1;

	localparam logic [2:0] SH_ACC  = 3'd0;
	localparam logic [2:0] SH_PC   = 3'd1;
	localparam logic [2:0] SH_ICR  = 3'd2;
	localparam logic [2:0] SH_MAR  = 3'd3;
	localparam logic [2:0] SH_MDR  = 3'd4;
	localparam logic [2:0] SH_CTRL = 3'd5;
	localparam logic [2:0] SH_MEM  = 3'd6;
	localparam logic [2:0] SH_NONE = 3'd7;

	typedef logic [3:0] kind_t;

	localparam kind_t K_NOP    = 4'd0;
	localparam kind_t K_IGN    = 4'd1;
	localparam kind_t K_SETI   = 4'd2;
	localparam kind_t K_SETM   = 4'd3;
	localparam kind_t K_LOAD   = 4'd4;
	localparam kind_t K_ACCOP  = 4'd5;
	localparam kind_t K_OP2    = 4'd6;
	localparam kind_t K_OP3    = 4'd7;
	localparam kind_t K_INCDEC = 4'd8;
	localparam kind_t K_STR    = 4'd9;
	localparam kind_t K_SHW    = 4'd10;
	localparam kind_t K_END    = 4'd11;

	localparam int Q_DEPTH = 2;

	typedef struct packed {
		logic [3:0]         op;
		logic               a_valid;
		logic [7:0]         a_addr;
		logic [1:0]         b_kind;
		logic [7:0]         b_addr;
		logic signed [31:0] b_value;
		logic [1:0]         c_kind;
		logic [7:0]         c_addr;
		logic [2:0]         show_sel;
	} in_t;

	typedef struct packed {
		logic signed [31:0] acc;
		logic [7:0]         mar;
		logic signed [31:0] mdr;
		logic [15:0]        pc;
		logic               running;
		logic signed [31:0] shown_value;
		logic               shown_valid;
		logic               ignored;
	} res_t;

	typedef struct packed {
		kind_t              kind;
		logic               neg;
		logic [2:0]         sel;
		logic [7:0]         a_addr;
		logic [7:0]         b_addr;
		logic [7:0]         c_addr;
		logic signed [31:0] b_value;
	} cmd_t;

endpackage

@@ hw/rtl/aie_chan_if.sv @@
// valid/ready channel carrying one beat of payload
interface aie_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/accumulator_instruction_execute.sv @@
// top level of the accumulator instruction execute block
// Executes one decoded instruction per beat on cmd and returns one result beat on res.
// After reset the data memory is cleared one word a cycle while cmd is held not ready.
// Each instruction then passes through the back end: its operands are read from the
// synchronous data memory, then it is computed, written back and loaded into the result
// register. The back end takes no new instruction until the last has executed, and it
// waits while res is stalled; a two-entry queue lets cmd keep accepting beats meanwhile.
module accumulator_instruction_execute #(
	parameter int MEM_WORDS = 256,
	parameter int DATA_BITS = 32
) (
	input logic        clk,
	input logic        arst_n,
	aie_chan_if.sink   cmd,
	aie_chan_if.source res
);
	logic          push_valid;
	aie_pkg::cmd_t push_data;
	logic          push_ready;
	logic          pop;
	logic          pop_valid;
	aie_pkg::cmd_t pop_data;
	logic          clearing;

	aie_front #(
		.MEM_WORDS (MEM_WORDS)
	) u_front (
		.cmd        (cmd),
		.hold       (clearing),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	aie_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data)
	);

	aie_back #(
		.MEM_WORDS (MEM_WORDS),
		.DATA_BITS (DATA_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (pop_valid),
		.q_data   (pop_data),
		.q_pop    (pop),
		.clearing (clearing),
		.res      (res)
	);
endmodule

@@ hw/rtl/aie_ram.sv @@
// generic ram, one write port and two registered read ports
module aie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata0 <= mem_q[raddr0];
			rdata1 <= mem_q[raddr1];
		end
	end
endmodule

@@ hw/rtl/aie_queue.sv @@
// two-entry queue of classified instructions between front and back
module aie_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	input  aie_pkg::cmd_t push_data,
	output logic          push_ready,
	input  logic          pop,
	output logic          pop_valid,
	output aie_pkg::cmd_t pop_data
);
	aie_pkg::cmd_t ent_q [aie_pkg::Q_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign push_ready = cnt_q != 2'(aie_pkg::Q_DEPTH);
	assign pop_valid  = cnt_q != 2'd0;
	assign pop_data   = ent_q[rd_ptr_q];
	assign push       = push_valid && push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end
endmodule

@@ hw/rtl/aie_front.sv @@
// front end: accepts instruction beats and classifies operand forms
module aie_front #(
	parameter int MEM_WORDS = 256
) (
	aie_chan_if.sink      cmd,
	input  logic          hold,
	output logic          push_valid,
	output aie_pkg::cmd_t push_data,
	input  logic          push_ready
);
	logic av;
	logic bv;
	logic cv;

	assign cmd.ready  = push_ready && !hold;
	assign push_valid = cmd.valid && !hold;

	assign av = cmd.data.a_valid && (32'(cmd.data.a_addr) < MEM_WORDS);
	assign bv = (cmd.data.b_kind == aie_pkg::BK_ADDR) && (32'(cmd.data.b_addr) < MEM_WORDS);
	assign cv = (cmd.data.c_kind == aie_pkg::CK_ADDR) && (32'(cmd.data.c_addr) < MEM_WORDS);

	always_comb begin
		push_data.kind    = aie_pkg::K_IGN;
		push_data.neg     = 1'b0;
		push_data.sel     = cmd.data.show_sel;
		push_data.a_addr  = cmd.data.a_addr;
		push_data.b_addr  = cmd.data.b_addr;
		push_data.c_addr  = cmd.data.c_addr;
		push_data.b_value = cmd.data.b_value;
		case (cmd.data.op)
			aie_pkg::OP_SET: begin
				if (av && cmd.data.b_kind == aie_pkg::BK_NUM) begin
					push_data.kind = aie_pkg::K_SETI;
				end else if (av && bv) begin
					push_data.kind = aie_pkg::K_SETM;
				end
			end
			aie_pkg::OP_LOAD: begin
				if (av) begin
					push_data.kind = aie_pkg::K_LOAD;
				end
			end
			aie_pkg::OP_ADD, aie_pkg::OP_SUB: begin
				push_data.neg = cmd.data.op == aie_pkg::OP_SUB;
				if (av && cmd.data.b_kind == aie_pkg::BK_NULL) begin
					push_data.kind = aie_pkg::K_ACCOP;
				end else if (av && bv && cmd.data.c_kind == aie_pkg::CK_NULL) begin
					push_data.kind = aie_pkg::K_OP2;
				end else if (av && bv && cv) begin
					push_data.kind = aie_pkg::K_OP3;
				end
			end
			aie_pkg::OP_INC, aie_pkg::OP_DEC: begin
				push_data.neg = cmd.data.op == aie_pkg::OP_DEC;
				if (av) begin
					push_data.kind = aie_pkg::K_INCDEC;
				end
			end
			aie_pkg::OP_STR: begin
				if (av) begin
					push_data.kind = aie_pkg::K_STR;
				end
			end
			aie_pkg::OP_SHW: begin
				if (cmd.data.show_sel == aie_pkg::SH_ICR) begin
					push_data.kind = aie_pkg::K_NOP;
				end else if (cmd.data.show_sel == aie_pkg::SH_NONE) begin
					push_data.kind = aie_pkg::K_IGN;
				end else if (cmd.data.show_sel == aie_pkg::SH_MEM && !av) begin
					push_data.kind = aie_pkg::K_IGN;
				end else begin
					push_data.kind = aie_pkg::K_SHW;
				end
			end
			aie_pkg::OP_PAUSE: begin
				push_data.kind = aie_pkg::K_NOP;
			end
			aie_pkg::OP_END: begin
				push_data.kind = aie_pkg::K_END;
			end
			default: begin
				push_data.kind = aie_pkg::K_IGN;
			end
		endcase
	end
endmodule

@@ hw/rtl/aie_back.sv @@
// back end: memory access, execution, machine registers and result register
module aie_back #(
	parameter int MEM_WORDS = 256,
	parameter int DATA_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  aie_pkg::cmd_t q_data,
	output logic          q_pop,
	output logic          clearing,
	aie_chan_if.source    res
);
	localparam int AW = $clog2(MEM_WORDS);

	typedef logic [DATA_BITS-1:0] word_t;

	logic          clr_q;
	logic [AW-1:0] clr_idx_q;
	logic          busy_s1;
	aie_pkg::cmd_t cmd_s1;
	word_t         acc_q;
	logic [7:0]    mar_q;
	word_t         mdr_q;
	logic [15:0]   pc_q;
	logic          run_q;
	logic          res_v_q;
	aie_pkg::res_t res_q;

	word_t         rd0;
	word_t         rd1;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	word_t         ram_wdata;
	logic          exec;

	word_t         bval;
	word_t         op_x;
	word_t         op_y;
	word_t         sum;
	word_t         acc_n;
	logic [7:0]    mar_n;
	word_t         mdr_n;
	logic [15:0]   pc_n;
	logic          run_n;
	logic [31:0]   shown_n;
	logic          shown_ok_n;
	logic          ign_n;
	logic          wr_n;
	logic [7:0]    wr_addr_n;
	word_t         wr_data_n;

	assign clearing = clr_q;
	assign q_pop    = q_valid && !busy_s1 && !clr_q;
	assign exec     = busy_s1 && (!res_v_q || res.ready);

	assign res.valid = res_v_q;
	assign res.data  = res_q;

	assign ram_we    = clr_q || (exec && wr_n);
	assign ram_waddr = clr_q ? clr_idx_q : AW'(wr_addr_n);
	assign ram_wdata = clr_q ? '0 : wr_data_n;

	aie_ram #(
		.WIDTH (DATA_BITS),
		.DEPTH (MEM_WORDS)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.re     (q_pop),
		.raddr0 (AW'(q_data.a_addr)),
		.raddr1 (AW'(q_data.b_addr)),
		.rdata0 (rd0),
		.rdata1 (rd1)
	);

	// shared add/sub for every arithmetic form
	assign bval = DATA_BITS'(cmd_s1.b_value);
	assign op_x = (cmd_s1.kind == aie_pkg::K_ACCOP) ? acc_q : rd0;
	assign op_y = (cmd_s1.kind == aie_pkg::K_ACCOP)  ? rd0 :
	              (cmd_s1.kind == aie_pkg::K_INCDEC) ? word_t'(1) : rd1;
	assign sum  = cmd_s1.neg ? op_x - op_y : op_x + op_y;

	always_comb begin
		acc_n      = acc_q;
		mar_n      = mar_q;
		mdr_n      = mdr_q;
		pc_n       = pc_q;
		run_n      = run_q;
		shown_n    = '0;
		shown_ok_n = 1'b0;
		ign_n      = 1'b0;
		wr_n       = 1'b0;
		wr_addr_n  = cmd_s1.a_addr;
		wr_data_n  = sum;
		if (!run_q) begin
			ign_n = 1'b1;
		end else begin
			// fetch effects
			mar_n = pc_q[7:0];
			mdr_n = '0;
			pc_n  = pc_q + 16'd1;
			case (cmd_s1.kind)
				aie_pkg::K_SETI: begin
					mar_n     = cmd_s1.a_addr;
					mdr_n     = bval;
					wr_n      = 1'b1;
					wr_data_n = bval;
				end
				aie_pkg::K_SETM: begin
					mar_n     = cmd_s1.a_addr;
					mdr_n     = rd1;
					wr_n      = 1'b1;
					wr_data_n = rd1;
				end
				aie_pkg::K_LOAD: begin
					mar_n = cmd_s1.a_addr;
					mdr_n = rd0;
					acc_n = rd0;
				end
				aie_pkg::K_ACCOP: begin
					mar_n = cmd_s1.a_addr;
					mdr_n = rd0;
					acc_n = sum;
				end
				aie_pkg::K_OP2: begin
					mar_n = cmd_s1.b_addr;
					mdr_n = sum;
					acc_n = sum;
				end
				aie_pkg::K_OP3: begin
					mar_n     = cmd_s1.c_addr;
					mdr_n     = sum;
					wr_n      = 1'b1;
					wr_addr_n = cmd_s1.c_addr;
				end
				aie_pkg::K_INCDEC: begin
					mar_n = cmd_s1.a_addr;
					mdr_n = sum;
					wr_n  = 1'b1;
				end
				aie_pkg::K_STR: begin
					mar_n     = cmd_s1.a_addr;
					mdr_n     = acc_q;
					wr_n      = 1'b1;
					wr_data_n = acc_q;
				end
				aie_pkg::K_SHW: begin
					shown_ok_n = 1'b1;
					case (cmd_s1.sel)
						aie_pkg::SH_ACC:  shown_n = 32'(acc_q);
						aie_pkg::SH_PC:   shown_n = 32'(pc_n);
						aie_pkg::SH_MAR:  shown_n = 32'(mar_n);
						aie_pkg::SH_MDR:  shown_n = 32'(mdr_n);
						aie_pkg::SH_CTRL: shown_n = 32'(run_q);
						aie_pkg::SH_MEM:  shown_n = 32'(rd0);
						default:          shown_n = '0;
					endcase
				end
				aie_pkg::K_END: begin
					run_n = 1'b0;
				end
				aie_pkg::K_NOP: begin
					ign_n = 1'b0;
				end
				default: begin
					ign_n = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
			busy_s1   <= 1'b0;
			acc_q     <= '0;
			mar_q     <= '0;
			mdr_q     <= '0;
			pc_q      <= '0;
			run_q     <= 1'b1;
			res_v_q   <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + AW'(1);
				if (clr_idx_q == AW'(MEM_WORDS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (q_pop) begin
				busy_s1 <= 1'b1;
			end else if (exec) begin
				busy_s1 <= 1'b0;
			end
			if (exec) begin
				acc_q   <= acc_n;
				mar_q   <= mar_n;
				mdr_q   <= mdr_n;
				pc_q    <= pc_n;
				run_q   <= run_n;
				res_v_q <= 1'b1;
			end else if (res.ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_s1 <= q_data;
		end
		if (exec) begin
			res_q.acc         <= 32'(acc_n);
			res_q.mar         <= mar_n;
			res_q.mdr         <= 32'(mdr_n);
			res_q.pc          <= pc_n;
			res_q.running     <= run_n;
			res_q.shown_value <= shown_n;
			res_q.shown_valid <= shown_ok_n;
			res_q.ignored     <= ign_n;
		end
	end
endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the accumulator instruction execute block
module testbench;

	localparam logic [3:0] OP_FIRST_UNKNOWN = 4'd10;
	localparam logic [3:0] OP_LAST          = 4'd15;
	localparam logic [1:0] BK_NONE          = 2'd3;
	localparam logic [1:0] CK_NONE          = 2'd2;
	localparam int RANDOM_ITEMS = 1620;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 20;

	class exec_scoreboard;
		logic [31:0] mem [256];
		logic [31:0] acc;
		logic [7:0]  mar;
		logic [31:0] mdr;
		logic [15:0] pc;
		logic        running;
		aie_pkg::res_t due[$];
		int          errors;

		function new();
			foreach (mem[i]) mem[i] = '0;
			acc = '0;
			mar = '0;
			mdr = '0;
			pc = '0;
			running = 1'b1;
			errors = 0;
		endfunction

		function void note_cmd(aie_pkg::in_t c);
			aie_pkg::res_t r;
			logic a_ok, b_ok, c_ok;
			logic [31:0] v1, v2, sum;
			r = '0;
			a_ok = c.a_valid;
			b_ok = c.b_kind == aie_pkg::BK_ADDR;
			c_ok = c.c_kind == aie_pkg::CK_ADDR;
			if (!running) begin
				r.ignored = 1'b1;
			end else begin
				mar = pc[7:0];
				mdr = '0;
				pc = pc + 16'd1;
				case (c.op)
				aie_pkg::OP_SET: begin
					if (a_ok && c.b_kind == aie_pkg::BK_NUM) begin
						mar = c.a_addr;
						mem[c.a_addr] = c.b_value;
						mdr = c.b_value;
					end else if (a_ok && b_ok) begin
						mdr = mem[c.b_addr];
						mar = c.a_addr;
						mem[c.a_addr] = mdr;
					end else begin
						r.ignored = 1'b1;
					end
				end
				aie_pkg::OP_LOAD: begin
					if (a_ok) begin
						mar = c.a_addr;
						mdr = mem[c.a_addr];
						acc = mdr;
					end else begin
						r.ignored = 1'b1;
					end
				end
				aie_pkg::OP_ADD, aie_pkg::OP_SUB: begin
					if (a_ok && c.b_kind == aie_pkg::BK_NULL) begin
						v1 = mem[c.a_addr];
						mar = c.a_addr;
						mdr = v1;
						acc = (c.op == aie_pkg::OP_SUB) ? acc - v1 : acc + v1;
					end else if (a_ok && b_ok && (c.c_kind == aie_pkg::CK_NULL || c_ok)) begin
						v1 = mem[c.a_addr];
						v2 = mem[c.b_addr];
						sum = (c.op == aie_pkg::OP_SUB) ? v1 - v2 : v1 + v2;
						if (c.c_kind == aie_pkg::CK_NULL) begin
							mar = c.b_addr;
							acc = sum;
						end else begin
							mem[c.c_addr] = sum;
							mar = c.c_addr;
						end
						mdr = sum;
					end else begin
						r.ignored = 1'b1;
					end
				end
				aie_pkg::OP_INC, aie_pkg::OP_DEC: begin
					if (a_ok) begin
						v1 = mem[c.a_addr];
						v1 = (c.op == aie_pkg::OP_INC) ? v1 + 32'd1 : v1 - 32'd1;
						mar = c.a_addr;
						mem[c.a_addr] = v1;
						mdr = v1;
					end else begin
						r.ignored = 1'b1;
					end
				end
				aie_pkg::OP_STR: begin
					if (a_ok) begin
						mar = c.a_addr;
						mem[c.a_addr] = acc;
						mdr = acc;
					end else begin
						r.ignored = 1'b1;
					end
				end
				aie_pkg::OP_SHW: begin
					r.shown_valid = 1'b1;
					case (c.show_sel)
					aie_pkg::SH_ACC: r.shown_value = acc;
					aie_pkg::SH_PC: r.shown_value = {16'd0, pc};
					aie_pkg::SH_ICR: r.shown_valid = 1'b0;
					aie_pkg::SH_MAR: r.shown_value = {24'd0, mar};
					aie_pkg::SH_MDR: r.shown_value = mdr;
					aie_pkg::SH_CTRL: r.shown_value = {31'd0, running};
					aie_pkg::SH_MEM: begin
						if (a_ok) begin
							r.shown_value = mem[c.a_addr];
						end else begin
							r.shown_valid = 1'b0;
							r.ignored = 1'b1;
						end
					end
					default: begin
						r.shown_valid = 1'b0;
						r.ignored = 1'b1;
					end
					endcase
				end
				aie_pkg::OP_PAUSE: ;
				aie_pkg::OP_END: running = 1'b0;
				default: r.ignored = 1'b1;
				endcase
			end
			r.acc = acc;
			r.mar = mar;
			r.mdr = mdr;
			r.pc = pc;
			r.running = running;
			due.push_back(r);
		endfunction

		function void compare(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				if (errors < 10)
					$display("mismatch on %s: expected %h, got %h", name, want, got);
				errors++;
			end
		endfunction

		function void check_res(aie_pkg::res_t got);
			aie_pkg::res_t want;
			if (due.size() == 0) begin
				if (errors < 10)
					$display("result beat with nothing outstanding: %p", got);
				errors++;
			end else begin
				want = due.pop_front();
				compare("acc", want.acc, got.acc);
				compare("mar", 32'(want.mar), 32'(got.mar));
				compare("mdr", want.mdr, got.mdr);
				compare("pc", 32'(want.pc), 32'(got.pc));
				compare("running", 32'(want.running), 32'(got.running));
				compare("shown_value", want.shown_value, got.shown_value);
				compare("shown_valid", 32'(want.shown_valid), 32'(got.shown_valid));
				compare("ignored", 32'(want.ignored), 32'(got.ignored));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   tx_calm;
	bit   rx_calm;
	int   quiet;
	exec_scoreboard sb = new();

	aie_chan_if #(.T(aie_pkg::in_t)) cmd_if ();
	aie_chan_if #(.T(aie_pkg::res_t)) res_if ();

	accumulator_instruction_execute DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_if.sink),
		.res(res_if.source)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// a calm stretch means no idling at all on that side
	function automatic int pick_gap(inout bit calm);
		if ($urandom_range(0, 39) == 0)
			calm = ~calm;
		return calm ? 0 : $urandom_range(0, 13);
	endfunction

	// mostly a few hot addresses so reads hit earlier writes
	function automatic logic [7:0] pick_addr();
		return ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
	endfunction

	function automatic aie_pkg::in_t mk(logic [3:0] op, logic av, logic [7:0] a,
			logic [1:0] bk, logic [7:0] b, logic [31:0] bv, logic [1:0] ck, logic [7:0] c,
			logic [2:0] sel);
		aie_pkg::in_t x;
		x.op = op;
		x.a_valid = av;
		x.a_addr = a;
		x.b_kind = bk;
		x.b_addr = b;
		x.b_value = bv;
		x.c_kind = ck;
		x.c_addr = c;
		x.show_sel = sel;
		return x;
	endfunction

	function automatic aie_pkg::in_t random_cmd();
		aie_pkg::in_t x;
		if ($urandom_range(0, 9) == 0)
			x.op = 4'($urandom_range(OP_FIRST_UNKNOWN, OP_LAST));
		else
			x.op = 4'($urandom_range(aie_pkg::OP_SET, aie_pkg::OP_PAUSE));
		x.a_valid = $urandom_range(0, 7) != 0;
		x.a_addr = pick_addr();
		x.b_kind = 2'($urandom);
		x.b_addr = pick_addr();
		case ($urandom_range(0, 3))
		0: x.b_value = 32'($signed($urandom_range(0, 8)) - 4);
		1: begin
			case ($urandom_range(0, 3))
			0: x.b_value = 32'h7fff_ffff;
			1: x.b_value = 32'h8000_0000;
			2: x.b_value = 32'hffff_ffff;
			default: x.b_value = 32'h0;
			endcase
		end
		default: x.b_value = $urandom;
		endcase
		x.c_kind = 2'($urandom);
		x.c_addr = pick_addr();
		x.show_sel = 3'($urandom);
		// most beats are well formed for their operation
		if ($urandom_range(0, 3) != 0) begin
			x.a_valid = 1'b1;
			case (x.op)
			aie_pkg::OP_SET: x.b_kind = $urandom_range(0, 1) ? aie_pkg::BK_NUM : aie_pkg::BK_ADDR;
			aie_pkg::OP_ADD, aie_pkg::OP_SUB: begin
				case ($urandom_range(0, 2))
				0: x.b_kind = aie_pkg::BK_NULL;
				1: begin
					x.b_kind = aie_pkg::BK_ADDR;
					x.c_kind = aie_pkg::CK_NULL;
				end
				default: begin
					x.b_kind = aie_pkg::BK_ADDR;
					x.c_kind = aie_pkg::CK_ADDR;
				end
				endcase
			end
			default: ;
			endcase
		end
		return x;
	endfunction

	task automatic send_cmd(input aie_pkg::in_t item);
		int gap;
		gap = pick_gap(tx_calm);
		if (gap > 0) begin
			cmd_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_if.valid = 1'b1;
		cmd_if.data = item;
		@(posedge clk);
		while (!cmd_if.ready) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		int stall;
		res_if.ready = 1'b0;
		forever begin
			stall = pick_gap(rx_calm);
			if (stall > 0) begin
				res_if.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_if.ready = 1'b1;
			@(posedge clk);
			while (!res_if.valid) @(posedge clk);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (cmd_if.valid && cmd_if.ready)
			sb.note_cmd(cmd_if.data);
		if (res_if.valid && res_if.ready)
			sb.check_res(res_if.data);
		if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
			quiet = 0;
		end else begin
			quiet = quiet + 1;
			if (quiet >= STALL_LIMIT) begin
				$display("testbench NOT OK");
				$finish;
			end
		end
	end

	initial begin
		aie_pkg::in_t plan[$];
		quiet = 0;
		arst_n = 1'b0;
		cmd_if.valid = 1'b0;
		cmd_if.data = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// extremes, every operation form and the invalid operand cases
		plan.push_back(mk(aie_pkg::OP_SET, 1'b1, 8'd0, aie_pkg::BK_NUM, 8'd0, 32'h7fff_ffff,
			CK_NONE, 8'd0, aie_pkg::SH_ACC));
		plan.push_back(mk(aie_pkg::OP_SET, 1'b1, 8'd255, aie_pkg::BK_NUM, 8'd0, 32'h8000_0000,
			CK_NONE, 8'd0, aie_pkg::SH_ACC));
		plan.push_back(mk(aie_pkg::OP_SET, 1'b1, 8'd1, aie_pkg::BK_ADDR, 8'd255, 32'h0,
			CK_NONE, 8'd0, aie_pkg::SH_ACC));
		plan.push_back(mk(aie_pkg::OP_LOAD, 1'b1, 8'd0, BK_NONE, 8'd0, 32'h0,
			CK_NONE, 8'd0, aie_pkg::SH_ACC));
		plan.push_back(mk(aie_pkg::OP_ADD, 1'b1, 8'd255, aie_pkg::BK_NULL, 8'd0, 32'h0,
			CK_NONE, 8'd0, aie_pkg::SH_ACC));
		plan.push_back(mk(aie_pkg::OP_INC, 1'b1, 8'd0, BK_NONE, 8'd0, 32'h0,
			CK_NONE, 8'd0, aie_pkg::SH_ACC));
		plan.push_back(mk(aie_pkg::OP_DEC, 1'b1, 8'd255, BK_NONE, 8'd0, 32'h0,
			CK_NONE, 8'd0, aie_pkg::SH_ACC));
		plan.push_back(mk(aie_pkg::OP_SUB, 1'b1, 8'd1, aie_pkg::BK_NULL, 8'd0, 32'h0,
			CK_NONE, 8'd0, aie_pkg::SH_ACC));
		plan.push_back(mk(aie_pkg::OP_ADD, 1'b1, 8'd0, aie_pkg::BK_ADDR, 8'd255, 32'h0,
			aie_pkg::CK_NULL, 8'd0, aie_pkg::SH_ACC));
		plan.push_back(mk(aie_pkg::OP_SUB, 1'b1, 8'd0, aie_pkg::BK_ADDR, 8'd1, 32'h0,
			aie_pkg::CK_ADDR, 8'd2, aie_pkg::SH_ACC));
		plan.push_back(mk(aie_pkg::OP_STR, 1'b1, 8'd3, BK_NONE, 8'd0, 32'h0,
			CK_NONE, 8'd0, aie_pkg::SH_ACC));
		for (int s = aie_pkg::SH_ACC; s <= aie_pkg::SH_NONE; s++)
			plan.push_back(mk(aie_pkg::OP_SHW, 1'b1, 8'd2, BK_NONE, 8'd0, 32'h0,
				CK_NONE, 8'd0, 3'(s)));
		plan.push_back(mk(aie_pkg::OP_SHW, 1'b0, 8'd2, BK_NONE, 8'd0, 32'h0,
			CK_NONE, 8'd0, aie_pkg::SH_MEM));
		plan.push_back(mk(aie_pkg::OP_PAUSE, 1'b1, 8'd0, BK_NONE, 8'd0, 32'h0,
			CK_NONE, 8'd0, aie_pkg::SH_ACC));
		plan.push_back(mk(OP_LAST, 1'b1, 8'hff, BK_NONE, 8'hff, 32'hffff_ffff, CK_NONE, 8'hff,
			aie_pkg::SH_NONE));
		plan.push_back(mk(aie_pkg::OP_SET, 1'b0, 8'd4, aie_pkg::BK_NUM, 8'd0, 32'h1234_5678,
			CK_NONE, 8'd0, aie_pkg::SH_ACC));
		plan.push_back(mk(aie_pkg::OP_ADD, 1'b1, 8'd0, BK_NONE, 8'd1, 32'h0,
			aie_pkg::CK_NULL, 8'd0, aie_pkg::SH_ACC));
		plan.push_back(mk(aie_pkg::OP_SUB, 1'b1, 8'd0, aie_pkg::BK_ADDR, 8'd1, 32'h0,
			CK_NONE, 8'd2, aie_pkg::SH_ACC));
		foreach (plan[i])
			send_cmd(plan[i]);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2 && sb.due.size() != 0) begin
				cmd_if.valid = 1'b0;
				while (sb.due.size() != 0) @(negedge clk);
			end
			send_cmd(random_cmd());
		end

		// halt, then beats on a halted machine
		send_cmd(mk(aie_pkg::OP_END, 1'b1, 8'd0, BK_NONE, 8'd0, 32'h0,
			CK_NONE, 8'd0, aie_pkg::SH_ACC));
		send_cmd(mk(aie_pkg::OP_LOAD, 1'b1, 8'd0, BK_NONE, 8'd0, 32'h0,
			CK_NONE, 8'd0, aie_pkg::SH_ACC));
		send_cmd(mk(aie_pkg::OP_SHW, 1'b1, 8'd0, BK_NONE, 8'd0, 32'h0,
			CK_NONE, 8'd0, aie_pkg::SH_PC));
		send_cmd(mk(aie_pkg::OP_INC, 1'b1, 8'd1, BK_NONE, 8'd0, 32'h0,
			CK_NONE, 8'd0, aie_pkg::SH_ACC));
		cmd_if.valid = 1'b0;

		while (sb.due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule

@@ files.f @@
hw/rtl/aie_pkg.sv
hw/rtl/aie_chan_if.sv
hw/rtl/aie_ram.sv
hw/rtl/aie_queue.sv
hw/rtl/aie_front.sv
hw/rtl/aie_back.sv
hw/rtl/accumulator_instruction_execute.sv
tb/testbench.sv
